// File: rtl/float_dot_product_lanes_assert.svh
// Assertion macros shared by the dot product RTL
`ifndef FLOAT_DOT_PRODUCT_LANES_ASSERT_SVH
`define FLOAT_DOT_PRODUCT_LANES_ASSERT_SVH

// same-cycle implication
`define FDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fdp_pkg.sv
// Shared types and constants of the lane-interleaved dot product
`default_nettype none
package fdp_pkg;

  localparam int LANES       = 8;
  localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        is_last;
  } item_t;

  // request handover between queue and execution side
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LZC,
    ST_NORM,
    ST_RND,
    ST_ADD,
    ST_RED0,
    ST_EMIT
  } bst_t;

endpackage
`default_nettype wire

// File: rtl/fdp_front.sv
// Input side: accepts element pairs into a short request queue
`default_nettype none
`include "float_dot_product_lanes_assert.svh"
module fdp_front
  import fdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // a_value[31:0], b_value[63:32]
  input  wire logic        s_tlast,  // is_last
  output qhead_t           head,
  input  wire logic        pop
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;

  assign s_tready = (count < QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{a_value: s_tdata[31:0], b_value: s_tdata[63:32], is_last: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `FDP_ASSERT_IMP(a_q_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `FDP_ASSERT_IMP(a_q_full, count == QCNT_W'(QUEUE_DEPTH), !s_tready, "ready while full")
  `FDP_ASSERT_NXT(a_q_push, push && !do_pop, count == $past(count) + 1'b1, "push lost")

endmodule
`default_nettype wire

// File: rtl/fdp_back.sv
// Execution side: multiply, lane accumulate and final reduction sequencer
`default_nettype none
`include "float_dot_product_lanes_assert.svh"
module fdp_back
  import fdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qhead_t      head,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // dot_result
);

  function automatic logic f_nan(input logic [31:0] x);
    f_nan = (x[30:0] > INF_BITS[30:0]);
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    f_inf = (x[30:0] == INF_BITS[30:0]);
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    f_zero = (x[30:0] == 31'd0);
  endfunction

  bst_t state, state_next;

  logic [31:0]       op_a, op_b, prod, acc;
  logic              last_r, reducing, mode_add, sgn;
  logic [LANE_W-1:0] lane_index, red_idx;
  logic [31:0]       lane_sums [LANES];
  logic [47:0]       w;
  logic [5:0]        lz;
  logic signed [10:0] ex;
  logic [26:0]       sig;

  // multiply operands
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        mul_sign, mul_special;
  logic [31:0] mul_special_val;
  logic signed [10:0] mul_exp;

  always_comb begin
    ma = {|op_a[30:23], op_a[22:0]};
    mb = {|op_b[30:23], op_b[22:0]};
    ea = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
    eb = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
    mul_sign = op_a[31] ^ op_b[31];
    mul_exp  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    mul_special     = 1'b1;
    mul_special_val = QNAN;
    if (f_nan(op_a) || f_nan(op_b)) begin
      mul_special_val = QNAN;
    end else if (f_inf(op_a) || f_inf(op_b)) begin
      mul_special_val = (f_zero(op_a) || f_zero(op_b)) ? QNAN : {mul_sign, INF_BITS[30:0]};
    end else if (f_zero(op_a) || f_zero(op_b)) begin
      mul_special_val = {mul_sign, 31'd0};
    end else begin
      mul_special = 1'b0;
    end
  end

  // adder operands and alignment
  logic [31:0] add_x, add_y, big, lesser;
  logic        add_special;
  logic [31:0] add_special_val;
  logic [7:0]  e_big, e_small, d;
  logic [26:0] mx, my, my_sh;
  logic [27:0] sum;

  always_comb begin
    add_x = reducing ? acc : lane_sums[lane_index];
    add_y = reducing ? lane_sums[red_idx] : prod;
    if (add_y[30:0] > add_x[30:0]) begin
      big    = add_y;
      lesser = add_x;
    end else begin
      big    = add_x;
      lesser = add_y;
    end
    e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_small = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
    d  = e_big - e_small;
    mx = {|big[30:23], big[22:0], 3'b000};
    my = {|lesser[30:23], lesser[22:0], 3'b000};
    if (d >= 8'd27) begin
      my_sh = {26'd0, |my};
    end else begin
      my_sh = (my >> d[4:0]) | {26'd0, |(my & ~(27'h7FF_FFFF << d[4:0]))};
    end
    if (big[31] == lesser[31]) begin
      sum = {1'b0, mx} + {1'b0, my_sh};
    end else begin
      sum = {1'b0, mx} - {1'b0, my_sh};
    end
    add_special     = 1'b1;
    add_special_val = QNAN;
    if (f_nan(add_x) || f_nan(add_y)) begin
      add_special_val = QNAN;
    end else if (f_inf(add_x) && f_inf(add_y)) begin
      add_special_val = (add_x[31] == add_y[31]) ? add_x : QNAN;
    end else if (f_inf(add_x)) begin
      add_special_val = add_x;
    end else if (f_inf(add_y)) begin
      add_special_val = add_y;
    end else if (f_zero(add_x) && f_zero(add_y)) begin
      add_special_val = {add_x[31] & add_y[31], 31'd0};
    end else if (f_zero(add_x)) begin
      add_special_val = add_y;
    end else if (f_zero(add_y)) begin
      add_special_val = add_x;
    end else if (sum == 28'd0) begin
      // exact cancellation gives +0
      add_special_val = 32'd0;
    end else begin
      add_special = 1'b0;
    end
  end

  // leading-zero search over the normaliser word
  logic [5:0] lz_next;
  always_comb begin
    lz_next = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (w[i]) lz_next = 6'(47 - i);
    end
  end

  logic [47:0] wn;
  logic [26:0] sig_next;
  always_comb begin
    wn       = w << lz;
    sig_next = wn[47:21] | {26'd0, |wn[20:0]};
  end

  // round and pack
  logic [8:0]  sh;
  logic [26:0] s2;
  logic [23:0] mrnd;
  logic [24:0] mrnd_inc;
  logic        inc;
  logic [7:0]  eu;
  logic [30:0] bits;
  logic [31:0] rnd_val;

  always_comb begin
    sh = 9'(11'sd1 - ex);
    s2 = sig;
    eu = ex[7:0];
    if (ex <= 11'sd0) begin
      eu = 8'd1;
      if (sh >= 9'd31) begin
        s2 = {26'd0, |sig};
      end else begin
        s2 = (sig >> sh[4:0]) | {26'd0, |(sig & ~(27'h7FF_FFFF << sh[4:0]))};
      end
    end
    mrnd     = s2[26:3];
    inc      = (s2[2:0] > 3'd4) || ((s2[2:0] == 3'd4) && mrnd[0]);
    mrnd_inc = {1'b0, mrnd} + {24'd0, inc};
    bits     = {eu - 8'd1, 23'd0} + {6'd0, mrnd_inc};
    if (bits >= INF_BITS[30:0]) bits = INF_BITS[30:0];
    rnd_val  = {sgn, bits};
    if (ex >= 11'sd255) rnd_val = {sgn, INF_BITS[30:0]};
  end

  // an addition finishes here
  logic        fin_valid;
  logic [31:0] fin_val;
  logic        emit;

  always_comb begin
    fin_valid = ((state == ST_ADD) && add_special) || ((state == ST_RND) && mode_add);
    fin_val   = (state == ST_ADD) ? add_special_val : rnd_val;
    emit      = (state == ST_EMIT) && (!m_tvalid || m_tready);
    pop       = (state == ST_IDLE) && head.valid;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head.valid) state_next = ST_MUL;
      ST_MUL:  state_next = mul_special ? ST_ADD : ST_LZC;
      ST_LZC:  state_next = ST_NORM;
      ST_NORM: state_next = ST_RND;
      ST_RND: begin
        if (!mode_add) begin
          state_next = ST_ADD;
        end else if (!reducing) begin
          state_next = last_r ? ST_RED0 : ST_IDLE;
        end else begin
          state_next = (red_idx == LANE_W'(LANES - 1)) ? ST_EMIT : ST_ADD;
        end
      end
      ST_ADD: begin
        if (!add_special) begin
          state_next = ST_LZC;
        end else if (!reducing) begin
          state_next = last_r ? ST_RED0 : ST_IDLE;
        end else begin
          state_next = (red_idx == LANE_W'(LANES - 1)) ? ST_EMIT : ST_ADD;
        end
      end
      ST_RED0: state_next = (LANES == 1) ? ST_EMIT : ST_ADD;
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      lane_index <= '0;
      reducing   <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < LANES; i++) lane_sums[i] <= 32'd0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fin_valid && !reducing) begin
        lane_sums[lane_index] <= fin_val;
        lane_index <= (lane_index == LANE_W'(LANES - 1)) ? '0 : lane_index + 1'b1;
      end
      if (state == ST_RED0) reducing <= 1'b1;
      if (emit) begin
        reducing   <= 1'b0;
        lane_index <= '0;
        for (int i = 0; i < LANES; i++) lane_sums[i] <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_a   <= head.item.a_value;
        op_b   <= head.item.b_value;
        last_r <= head.item.is_last;
      end
      ST_MUL: begin
        prod     <= mul_special_val;
        w        <= ma * mb;
        ex       <= mul_exp;
        sgn      <= mul_sign;
        mode_add <= 1'b0;
      end
      ST_LZC:  lz <= lz_next;
      ST_NORM: begin
        sig <= sig_next;
        ex  <= ex - $signed({5'd0, lz});
      end
      ST_RND: if (!mode_add) prod <= rnd_val;
      ST_ADD: begin
        w        <= {sum, 20'd0};
        ex       <= $signed({3'b000, e_big}) + 11'sd1;
        sgn      <= big[31];
        mode_add <= 1'b1;
      end
      ST_RED0: begin
        acc     <= lane_sums[0];
        red_idx <= LANE_W'(1);
      end
      ST_EMIT: if (emit) m_tdata <= acc;
      default: ;
    endcase
    if (fin_valid && reducing) begin
      acc     <= fin_val;
      red_idx <= red_idx + 1'b1;
    end
  end

  `FDP_ASSERT_IMP(a_emit_red, state == ST_EMIT, reducing, "emit outside reduction")
  `FDP_ASSERT_IMP(a_idle_acc, state == ST_IDLE, !reducing, "reduction flag left set")
  `FDP_ASSERT_NXT(a_fin_idle, fin_valid && !reducing && !last_r, state == ST_IDLE,
                  "accumulate did not return to idle")

endmodule
`default_nettype wire

// File: rtl/float_dot_product_lanes.sv
// Top level of the lane-interleaved single-precision dot product
// Each request carries one element pair; its product is rounded and added to lane
// k mod 8 with round-to-nearest-even, and a request with tlast set returns the
// eight lane partials summed from lane 0 upwards, then clears the lanes. Requests
// enter a two-deep queue, so up to two are taken while the execution sequencer
// works. One shared multiply/add/normalise/round datapath sets the rate: a pair
// runs the multiply, then the add, each with normalise and round (zero, infinite
// or NaN operands skip these); a last pair adds the reduction and output load.
`default_nettype none
module float_dot_product_lanes
  import fdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // a_value[31:0], b_value[63:32]
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // dot_result[31:0]
);

  qhead_t head;
  logic   pop;

  fdp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .head     (head),
    .pop      (pop)
  );

  fdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
